// ----- rtl/core/tcw_pkg.sv -----
// Shared types and constants for the text console writer.
package tcw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 4;

    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_FG = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BG = 2'd1;

    localparam logic [CFG_DATA_W-1:0] FG_RESET = 4'hF;
    localparam logic [CFG_DATA_W-1:0] BG_RESET = 4'h0;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] BLANK_CODE   = 8'h20;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } t_in_word;

    typedef struct packed {
        logic [4:0] cursor_row_out;
        logic [6:0] cursor_col_out;
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
    } t_out_word;

    typedef struct packed {
        logic [7:0] attr;
        logic [7:0] ch;
    } t_cell;

endpackage

// ----- rtl/core/tcw_cell_ram.sv -----
// Screen cell memory: one write port, one registered read port.
module tcw_cell_ram #(
    parameter int DEPTH  = tcw_pkg::DEF_COLUMNS * tcw_pkg::DEF_ROWS,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [ADDR_W-1:0]   i_waddr,
    input  tcw_pkg::t_cell      i_wdata,
    input  logic                i_re,
    input  logic [ADDR_W-1:0]   i_raddr,
    output tcw_pkg::t_cell      o_rdata
);
    import tcw_pkg::*;

    t_cell r_mem [DEPTH];
    t_cell r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/text_console_writer_core.sv -----
// Text console writer: cursor control, sweep sequencer and cell memory.
//
// A put of an ordinary byte, a newline that does not scroll, a read outside the screen and the
// unused command are completed in the idle state as they are taken; a read inside the screen
// goes on to a read state that returns the cell. A clear runs through the accept step, a
// blank sweep of every cell and a closing step. A newline or wrap on the last row runs through
// the accept step, a copy of every row but the first through the registered read port, a
// blank sweep of the last row and a closing step. The cell memory has a single write port, so
// every sweep writes one cell at a time. After reset a clearing pass zeros all ROWS*COLUMNS
// cells (2000 at 80 by 25); no word is taken until it ends, while configuration writes are
// taken at any time. A finished result waits in an output register; once the sequencer is
// idle, the next word is taken as soon as that register is free or being drained.
module text_console_writer_core #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  tcw_pkg::t_in_word                    i_in_word,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output tcw_pkg::t_out_word                   o_out_word,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [tcw_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [tcw_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import tcw_pkg::*;

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = $clog2(CELLS + 1);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS + 1);

    localparam logic [ADDR_W-1:0] COLS_A = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] COPY_A = ADDR_W'(CELLS - COLUMNS);
    localparam logic [CNT_W-1:0]  COLS_C = CNT_W'(COLUMNS);
    localparam logic [CNT_W-1:0]  CELLS_C = CNT_W'(CELLS);
    localparam logic [CNT_W-1:0]  LAST_C = CNT_W'(CELLS - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  COL_END = COL_W'(COLUMNS);

    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SCROLL = 3'd2;
    localparam logic [2:0] ST_BLANK  = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;
    localparam logic [2:0] ST_READ   = 3'd5;

    logic [2:0]            r_state, n_state;
    logic [ROW_W-1:0]      r_row, n_row;
    logic [COL_W-1:0]      r_col, n_col;
    logic [CNT_W-1:0]      r_src, n_src;
    logic [CNT_W-1:0]      r_dst, n_dst;
    logic                  r_rvld, n_rvld;
    logic                  r_pend, n_pend;
    logic [7:0]            r_pch, n_pch;
    logic                  r_out_valid, n_out_valid;
    t_out_word             r_out, n_out;
    logic [CFG_DATA_W-1:0] r_fg, r_bg;

    logic                  mem_we, mem_re;
    logic [ADDR_W-1:0]     mem_waddr, mem_raddr;
    t_cell                 mem_wdata, mem_rdata;

    logic                  accept;
    logic [7:0]            attr;
    logic                  last_row, wrap, rd_hit, fin_now;
    logic [ROW_W-1:0]      put_row;
    logic [COL_W-1:0]      put_col;
    logic [ADDR_W-1:0]     put_addr, rd_addr;

    assign o_in_ready  = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;
    assign o_cfg_ready = 1'b1;

    assign attr     = {r_bg, r_fg};
    assign last_row = (r_row == LAST_ROW);
    assign wrap     = (r_col >= COL_END);
    assign put_row  = wrap ? r_row + 1'b1 : r_row;
    assign put_col  = wrap ? '0 : r_col;
    assign put_addr = ADDR_W'(put_row) * COLS_A + ADDR_W'(put_col);
    assign rd_hit   = (int'(i_in_word.read_row) < ROWS) && (int'(i_in_word.read_col) < COLUMNS);
    assign rd_addr  = ADDR_W'(i_in_word.read_row) * COLS_A + ADDR_W'(i_in_word.read_col);

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_src       = r_src;
        n_dst       = r_dst;
        n_rvld      = 1'b0;
        n_pend      = r_pend;
        n_pch       = r_pch;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_waddr   = r_dst[ADDR_W-1:0];
        mem_wdata   = '{attr: attr, ch: BLANK_CODE};
        mem_re      = 1'b0;
        mem_raddr   = r_src[ADDR_W-1:0];
        fin_now     = 1'b0;
        case (r_state)
            ST_INIT: begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                if (r_dst == LAST_C) begin
                    n_state = ST_IDLE;
                end else begin
                    n_dst = r_dst + 1'b1;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    case (i_in_word.cmd)
                        CMD_PUT: begin
                            if (i_in_word.char_code == NEWLINE_CODE) begin
                                n_col = '0;
                                if (!last_row) begin
                                    n_row   = r_row + 1'b1;
                                    fin_now = 1'b1;
                                end else begin
                                    n_state = ST_SCROLL;
                                    n_src   = COLS_C;
                                    n_dst   = '0;
                                    n_pend  = 1'b0;
                                end
                            end else if (wrap && last_row) begin
                                n_col   = COL_W'(1);
                                n_pend  = 1'b1;
                                n_pch   = i_in_word.char_code;
                                n_state = ST_SCROLL;
                                n_src   = COLS_C;
                                n_dst   = '0;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = put_addr;
                                mem_wdata = '{attr: attr, ch: i_in_word.char_code};
                                n_row     = put_row;
                                n_col     = put_col + 1'b1;
                                fin_now   = 1'b1;
                            end
                        end
                        CMD_CLEAR: begin
                            n_dst   = '0;
                            n_pend  = 1'b0;
                            n_state = ST_BLANK;
                        end
                        CMD_READ: begin
                            if (rd_hit) begin
                                mem_re    = 1'b1;
                                mem_raddr = rd_addr;
                                n_state   = ST_READ;
                            end else begin
                                fin_now = 1'b1;
                            end
                        end
                        default: begin
                            fin_now = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCROLL: begin
                mem_re    = (r_src != CELLS_C);
                n_rvld    = mem_re;
                mem_we    = r_rvld;
                mem_wdata = mem_rdata;
                if (mem_re) begin
                    n_src = r_src + 1'b1;
                end
                if (r_rvld) begin
                    n_dst = r_dst + 1'b1;
                end
                if (!mem_re && !r_rvld) begin
                    n_state = ST_BLANK;
                end
            end
            ST_BLANK: begin
                mem_we = 1'b1;
                if (r_dst == LAST_C) begin
                    n_state = ST_FINISH;
                end else begin
                    n_dst = r_dst + 1'b1;
                end
            end
            ST_FINISH: begin
                mem_we    = r_pend;
                mem_waddr = COPY_A;
                mem_wdata = '{attr: attr, ch: r_pch};
                n_pend    = 1'b0;
                fin_now   = 1'b1;
                n_state   = ST_IDLE;
            end
            ST_READ: begin
                n_out_valid = 1'b1;
                n_out       = '{cursor_row_out: 5'(r_row), cursor_col_out: 7'(r_col),
                                cell_char: mem_rdata.ch, cell_attr: mem_rdata.attr};
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (fin_now) begin
            n_out_valid = 1'b1;
            n_out       = '{cursor_row_out: 5'(n_row), cursor_col_out: 7'(n_col),
                            cell_char: 8'd0, cell_attr: 8'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_row       <= '0;
            r_col       <= '0;
            r_src       <= '0;
            r_dst       <= '0;
            r_rvld      <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_src       <= n_src;
            r_dst       <= n_dst;
            r_rvld      <= n_rvld;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pch <= n_pch;
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= FG_RESET;
            r_bg <= BG_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FG:  r_fg <= i_cfg_data;
                CFG_BG:  r_bg <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tcw_cell_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> (!r_out_valid || i_out_ready))
        else $error("word taken while result register is full");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(r_row) < ROWS) && (int'(r_col) <= COLUMNS))
        else $error("cursor out of screen range");

    a_copy_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCROLL && r_rvld) |-> (r_dst < r_src))
        else $error("scroll copy destination not below source");

    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |=> (r_out_valid && r_state == ST_IDLE))
        else $error("read did not produce a result");

    a_finish_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH) |=> (r_out_valid && !r_pend))
        else $error("sweep did not produce a result");

endmodule
